### rtl/bcsg_pkg.sv
// bcsg_pkg: word types, fixed-point constants, register indexes, FSM states
// and the binomial coefficient table for the Bezier segment generator.
// No dependencies.
`timescale 1ns / 1ps

package bcsg_pkg;

	// fixed point: unsigned blends with FRAC_BITS fraction bits, 1.0 included
	localparam int FRAC_BITS = 30;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

	localparam int COORD_W  = 16;
	localparam int DEGREE_W = 4;
	localparam int STEPS_W  = 7;
	localparam int CFG_W    = 7;

	// binomials for every degree the 4-bit register can hold
	localparam int BINOM_N = 16;
	localparam int BINOM_W = 13;
	// point times binomial, and that times a blend
	localparam int PC_W    = COORD_W + BINOM_W + 1;
	localparam int PROD_W  = PC_W + Q_W + 1;
	localparam int ACC_W   = COORD_W + FRAC_BITS + 2;

	// register indexes
	localparam logic CFG_DEGREE = 1'b0;
	localparam logic CFG_STEPS  = 1'b1;

	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd3;
	localparam logic [STEPS_W-1:0]  STEPS_RESET  = 7'd16;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] seg_start_x;
		logic signed [COORD_W-1:0] seg_start_y;
		logic signed [COORD_W-1:0] seg_end_x;
		logic signed [COORD_W-1:0] seg_end_y;
		logic                      last_segment;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_LOAD,
		ST_WMUL,
		ST_MAC1,
		ST_MAC2,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic pt_wr;       // store the accepted point
		logic curve_start; // clear point count, arm divider and step counter
		logic div_run;     // one divider iteration
		logic step_start;  // clear sums, k = 0, power = 1.0
		logic k_load;      // blend seed and point*binomial for term k
		logic wmul;        // blend *= (1-u)
		logic mac1;        // term products; power *= u
		logic mac2;        // accumulate, k++
		logic out_load;    // emit segment, advance u
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;       // this point completes the curve
		logic div_last;
		logic k_is_n;
		logic wcnt_one;
		logic step_last;
		logic out_free;
	} status_t;

	typedef logic [BINOM_N-1:0][BINOM_N-1:0][BINOM_W-1:0] binom_tab_t;

	// Pascal triangle, evaluated at elaboration
	function automatic binom_tab_t build_binom();
		binom_tab_t t;
		t = '0;
		for (int n = 0; n < BINOM_N; n++) begin
			t[n][0] = BINOM_W'(1);
			for (int k = 1; k <= n; k++) begin
				t[n][k] = t[n-1][k-1] + ((k < n) ? t[n-1][k] : BINOM_W'(0));
			end
		end
		return t;
	endfunction

endpackage

### rtl/bcsg_ctrl.sv
// bcsg_ctrl: sequencing state machine of the Bezier segment generator.
// Depends on bcsg_pkg (state_t, cmd_t, status_t).
`timescale 1ns / 1ps

module bcsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bcsg_pkg::status_t sts,
	output bcsg_pkg::cmd_t    cmd
);

	bcsg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bcsg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.pt_wr = 1'b1;
					if (sts.full) begin
						cmd.curve_start = 1'b1;
						state_d = bcsg_pkg::ST_DIV;
					end
				end
			end
			bcsg_pkg::ST_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_last) begin
					state_d = bcsg_pkg::ST_STEP;
				end
			end
			bcsg_pkg::ST_STEP: begin
				cmd.step_start = 1'b1;
				state_d = bcsg_pkg::ST_LOAD;
			end
			bcsg_pkg::ST_LOAD: begin
				cmd.k_load = 1'b1;
				state_d = sts.k_is_n ? bcsg_pkg::ST_MAC1 : bcsg_pkg::ST_WMUL;
			end
			bcsg_pkg::ST_WMUL: begin
				cmd.wmul = 1'b1;
				if (sts.wcnt_one) begin
					state_d = bcsg_pkg::ST_MAC1;
				end
			end
			bcsg_pkg::ST_MAC1: begin
				cmd.mac1 = 1'b1;
				state_d = bcsg_pkg::ST_MAC2;
			end
			bcsg_pkg::ST_MAC2: begin
				cmd.mac2 = 1'b1;
				state_d = sts.k_is_n ? bcsg_pkg::ST_OUT : bcsg_pkg::ST_LOAD;
			end
			bcsg_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = sts.step_last ? bcsg_pkg::ST_IDLE : bcsg_pkg::ST_STEP;
				end
			end
			default: begin
				state_d = bcsg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/bcsg_dp.sv
// bcsg_dp: control point store, u divider and stepper, blend multiplier,
// term multiply-accumulate and output register of the Bezier generator.
// Depends on bcsg_pkg.
`timescale 1ns / 1ps

module bcsg_dp #(
	parameter int MAX_DEGREE = 15,
	parameter int MAX_STEPS  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcsg_pkg::cmd_t                cmd,
	output bcsg_pkg::status_t             sts,
	input  bcsg_pkg::in_word_t            in_word,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bcsg_pkg::CFG_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bcsg_pkg::out_word_t           out_word
);

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DIV_W = $clog2(bcsg_pkg::Q_W);
	localparam int F     = bcsg_pkg::FRAC_BITS;
	localparam int QW    = bcsg_pkg::Q_W;
	localparam int SW    = bcsg_pkg::STEPS_W;
	localparam bcsg_pkg::binom_tab_t BINOM = bcsg_pkg::build_binom();

	// configuration
	logic [bcsg_pkg::DEGREE_W-1:0] degree_q;
	logic [SW-1:0]                 step_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q     <= bcsg_pkg::DEGREE_RESET;
			step_count_q <= bcsg_pkg::STEPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bcsg_pkg::CFG_DEGREE: degree_q     <= cfg_data[bcsg_pkg::DEGREE_W-1:0];
				bcsg_pkg::CFG_STEPS:  step_count_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	logic [bcsg_pkg::DEGREE_W-1:0] n_deg;
	logic [SW-1:0]                 steps;

	assign n_deg = (32'(degree_q) > MAX_DEGREE) ? bcsg_pkg::DEGREE_W'(MAX_DEGREE) : degree_q;
	assign steps = (step_count_q == '0) ? SW'(1) :
		((32'(step_count_q) > MAX_STEPS) ? SW'(MAX_STEPS) : step_count_q);

	// control point store
	logic signed [bcsg_pkg::COORD_W-1:0] store_x [DEPTH];
	logic signed [bcsg_pkg::COORD_W-1:0] store_y [DEPTH];
	logic [CNT_W-1:0] pts_q;

	always_ff @(posedge clk) begin
		if (cmd.pt_wr && (32'(pts_q) < DEPTH)) begin
			store_x[IDX_W'(pts_q)] <= in_word.point_x;
			store_y[IDX_W'(pts_q)] <= in_word.point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cmd.curve_start) begin
			pts_q <= '0;
		end else if (cmd.pt_wr && (32'(pts_q) < DEPTH)) begin
			pts_q <= pts_q + CNT_W'(1);
		end
	end

	// count after this word reaches n+1
	assign sts.full = ((32'(pts_q) < DEPTH) ? (32'(pts_q) + 1) : 32'(pts_q)) >= 32'(n_deg) + 1;

	// 2^F / steps, one quotient bit per cycle
	logic [DIV_W-1:0] div_cnt_q;
	logic [SW-1:0]    div_rem_q;
	logic [QW-1:0]    div_quo_q;
	logic [SW:0]      div_t;
	logic             div_ge;

	assign div_t  = {div_rem_q, (div_cnt_q == DIV_W'(F))};
	assign div_ge = div_t >= {1'b0, steps};

	always_ff @(posedge clk) begin
		if (cmd.curve_start) begin
			div_cnt_q <= DIV_W'(F);
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (cmd.div_run) begin
			div_cnt_q <= div_cnt_q - DIV_W'(1);
			div_rem_q <= div_ge ? SW'(div_t - {1'b0, steps}) : SW'(div_t);
			div_quo_q <= {div_quo_q[QW-2:0], div_ge};
		end
	end

	assign sts.div_last = (div_cnt_q == '0);

	// u stepper: u += q0 each step, remainder carried
	logic [QW-1:0] u_q;
	logic [SW-1:0] urem_q;
	logic [SW-1:0] step_q;
	logic [SW:0]   urem_sum;
	logic          u_carry;
	logic [QW-1:0] w;

	assign urem_sum = {1'b0, urem_q} + {1'b0, div_rem_q};
	assign u_carry  = urem_sum >= {1'b0, steps};
	assign w        = bcsg_pkg::Q_ONE - u_q;

	always_ff @(posedge clk) begin
		if (cmd.curve_start) begin
			u_q    <= '0;
			urem_q <= '0;
			step_q <= '0;
		end else if (cmd.out_load) begin
			u_q    <= u_q + div_quo_q + QW'(u_carry);
			urem_q <= u_carry ? SW'(urem_sum - {1'b0, steps}) : SW'(urem_sum);
			step_q <= step_q + SW'(1);
		end
	end

	assign sts.step_last = (step_q == steps - SW'(1));

	// blend unit: one truncated Q multiply per cycle
	logic [bcsg_pkg::DEGREE_W-1:0] k_q;
	logic [bcsg_pkg::DEGREE_W-1:0] wcnt_q;
	logic [QW-1:0]                 v_q;
	logic [QW-1:0]                 pw_q;
	logic [QW-1:0]                 mul_a, mul_b;
	logic [2*QW-1:0]               mul_p;

	assign mul_a = cmd.mac1 ? pw_q : v_q;
	assign mul_b = cmd.mac1 ? u_q : w;
	assign mul_p = mul_a * mul_b;

	assign sts.k_is_n   = (k_q == n_deg);
	assign sts.wcnt_one = (wcnt_q == bcsg_pkg::DEGREE_W'(1));

	// term products and sums
	logic signed [bcsg_pkg::PC_W-1:0]   pcx_q, pcy_q;
	logic signed [bcsg_pkg::PROD_W-1:0] prodx_q, prody_q;
	logic signed [bcsg_pkg::ACC_W-1:0]  accx_q, accy_q;
	logic [bcsg_pkg::BINOM_W-1:0]       binom;

	assign binom = BINOM[n_deg][k_q];

	always_ff @(posedge clk) begin
		if (cmd.step_start) begin
			k_q    <= '0;
			pw_q   <= bcsg_pkg::Q_ONE;
			accx_q <= '0;
			accy_q <= '0;
		end
		if (cmd.k_load) begin
			v_q    <= pw_q;
			wcnt_q <= n_deg - k_q;
			pcx_q  <= store_x[IDX_W'(k_q)] * $signed({1'b0, binom});
			pcy_q  <= store_y[IDX_W'(k_q)] * $signed({1'b0, binom});
		end
		if (cmd.wmul) begin
			v_q    <= mul_p[F +: QW];
			wcnt_q <= wcnt_q - bcsg_pkg::DEGREE_W'(1);
		end
		if (cmd.mac1) begin
			prodx_q <= pcx_q * $signed({1'b0, v_q});
			prody_q <= pcy_q * $signed({1'b0, v_q});
			pw_q    <= mul_p[F +: QW];
		end
		if (cmd.mac2) begin
			accx_q <= accx_q + prodx_q[bcsg_pkg::ACC_W-1:0];
			accy_q <= accy_q + prody_q[bcsg_pkg::ACC_W-1:0];
			k_q    <= k_q + bcsg_pkg::DEGREE_W'(1);
		end
	end

	// truncate toward zero
	logic [bcsg_pkg::ACC_W-1:0]   magx, magy;
	logic [bcsg_pkg::COORD_W-1:0] cx, cy;

	assign magx = accx_q[bcsg_pkg::ACC_W-1] ? (-accx_q) : accx_q;
	assign magy = accy_q[bcsg_pkg::ACC_W-1] ? (-accy_q) : accy_q;
	assign cx = accx_q[bcsg_pkg::ACC_W-1] ? (-magx[F +: bcsg_pkg::COORD_W])
		: magx[F +: bcsg_pkg::COORD_W];
	assign cy = accy_q[bcsg_pkg::ACC_W-1] ? (-magy[F +: bcsg_pkg::COORD_W])
		: magy[F +: bcsg_pkg::COORD_W];

	// output register and previous point
	logic                         out_valid_q;
	bcsg_pkg::out_word_t          out_word_q;
	logic [bcsg_pkg::COORD_W-1:0] prev_x_q, prev_y_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				prev_x_q    <= cx;
				prev_y_q    <= cy;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word_q.seg_start_x  <= (step_q == '0) ? cx : prev_x_q;
			out_word_q.seg_start_y  <= (step_q == '0) ? cy : prev_y_q;
			out_word_q.seg_end_x    <= cx;
			out_word_q.seg_end_y    <= cy;
			out_word_q.last_segment <= sts.step_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

### rtl/bezier_curve_segment_generator.sv
// Bezier segment generator top: control FSM plus datapath.
// Point words are taken while idle; the word completing a curve starts the bit-serial
// divider, then each step walks terms k = 0..n (n = degree) through the shared blend
// multiplier and may wait on an output stall. Throughput: one curve at a time.
// Reset (arst_n low): idle, no points held, degree 3, 16 steps, output empty.
`timescale 1ns / 1ps

// Words in: control points, one x,y pair per word. Once degree+1 points are held,
// the curve P(u) = sum C(n,k) u^k (1-u)^(n-k) P_k is sampled at u = i/steps,
// i = 0..steps-1, and one segment word per sample leaves, previous point to
// current; the first is degenerate and the last carries last_segment.
//
// Per sample the datapath walks k = 0..n: the blend starts at u^k (kept as a
// running power) and is multiplied n-k times by (1-u), each product truncated
// to Q1.30; point*binomial is formed alongside and the two are multiplied and
// summed exactly. The sum is truncated toward zero to a 16-bit coordinate.
// u itself comes from one bit-serial division 2^30/steps per curve and then
// steps by quotient plus carried remainder.
// Input is taken only between curves; a finished word in the output register
// does not hold back the next point.

module bezier_curve_segment_generator #(
	parameter int MAX_DEGREE = 15,
	parameter int MAX_STEPS  = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bcsg_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bcsg_pkg::out_word_t         out_word,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bcsg_pkg::CFG_W-1:0]  cfg_data
);

	bcsg_pkg::cmd_t    cmd;
	bcsg_pkg::status_t sts;

	// sequencing
	bcsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, divider, multipliers, sums, output register
	bcsg_dp #(
		.MAX_DEGREE (MAX_DEGREE),
		.MAX_STEPS  (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

### tb/tb_bezier_curve_segment_generator.sv
// Testbench for bezier_curve_segment_generator: drives control-point words
// and register writes, and checks every segment word against a fixed-point
// curve predictor held in a scoreboard class. Depends on rtl/bcsg_pkg.sv.
`timescale 1ns / 1ps

module tb_bezier_curve_segment_generator;
	import bcsg_pkg::*;

	localparam int  LIMIT_CYCLES = 1000000;
	localparam int  DRAIN_CYCLES = 200;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  ITEM_TARGET  = 170;
	localparam int  STORE_N      = 16;
	localparam int  STEP_CAP     = 64;

	// Curve predictor and queue of segment words still owed by the block.
	class seg_scoreboard;
		logic [DEGREE_W-1:0] degree;
		logic [STEPS_W-1:0]  steps;
		longint              px[STORE_N];
		longint              py[STORE_N];
		int                  loaded;
		out_word_t           owed[$];
		int                  errors;
		int                  points;
		int                  curves;
		int                  segments;

		function new();
			degree   = DEGREE_RESET;
			steps    = STEPS_RESET;
			loaded   = 0;
			errors   = 0;
			points   = 0;
			curves   = 0;
			segments = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] v);
			if (idx == CFG_DEGREE) begin
				degree = v[DEGREE_W-1:0];
			end else begin
				steps = v[STEPS_W-1:0];
			end
		endfunction

		function longint choose(int n, int k);
			longint c;
			c = 1;
			for (int j = 0; j < k; j++) begin
				c = c * (n - j) / (j + 1);
			end
			return c;
		endfunction

		// truncated Q1.30 blend times the exact binomial
		function longint bern_weight(int k, int n, longint u);
			longint v;
			longint one;
			one = longint'(1) <<< FRAC_BITS;
			v = one;
			for (int j = 0; j < k; j++) begin
				v = (v * u) >>> FRAC_BITS;
			end
			for (int j = 0; j < n - k; j++) begin
				v = (v * (one - u)) >>> FRAC_BITS;
			end
			return v * choose(n, k);
		endfunction

		function void note_point(in_word_t w);
			int        n;
			int        st;
			longint    u;
			longint    sx;
			longint    sy;
			longint    b;
			longint    one;
			longint    cx;
			longint    cy;
			longint    lx;
			longint    ly;
			out_word_t e;
			one = longint'(1) <<< FRAC_BITS;
			points++;
			if (loaded < STORE_N) begin
				px[loaded] = longint'(w.point_x);
				py[loaded] = longint'(w.point_y);
				loaded++;
			end
			n = int'(degree);
			if (loaded < n + 1) return;
			st = int'(steps);
			if (st == 0) st = 1;
			if (st > STEP_CAP) st = STEP_CAP;
			lx = 0;
			ly = 0;
			for (int i = 0; i < st; i++) begin
				u  = (longint'(i) <<< FRAC_BITS) / st;
				sx = 0;
				sy = 0;
				for (int k = 0; k <= n; k++) begin
					b  = bern_weight(k, n, u);
					sx += px[k] * b;
					sy += py[k] * b;
				end
				// signed division truncates toward zero
				cx = sx / one;
				cy = sy / one;
				if (i == 0) begin
					lx = cx;
					ly = cy;
				end
				e.seg_start_x  = lx[15:0];
				e.seg_start_y  = ly[15:0];
				e.seg_end_x    = cx[15:0];
				e.seg_end_y    = cy[15:0];
				e.last_segment = (i == st - 1);
				owed.push_back(e);
				lx = cx;
				ly = cy;
			end
			loaded = 0;
			curves++;
		endfunction

		function void check_segment(out_word_t got);
			out_word_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected segment word %h", got);
				return;
			end
			e = owed.pop_front();
			segments++;
			if (got !== e) begin
				errors++;
				if (errors <= 10) begin
					$display("segment mismatch: exp s=(%0d,%0d) e=(%0d,%0d) last=%0b",
						e.seg_start_x, e.seg_start_y, e.seg_end_x, e.seg_end_y,
						e.last_segment);
					$display("                  got s=(%0d,%0d) e=(%0d,%0d) last=%0b",
						got.seg_start_x, got.seg_start_y, got.seg_end_x,
						got.seg_end_y, got.last_segment);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_word_t         in_word = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_word;
	logic             cfg_we = 1'b0;
	logic             cfg_index = CFG_DEGREE;
	logic [CFG_W-1:0] cfg_data = '0;

	seg_scoreboard sb = new();
	bit            calm = 1'b0;      // no idling on either side
	bit            hold_req = 1'b0;  // ask the receiver for a long hold-off
	int            hold_left = 0;
	int            cycles = 0;
	int            sent = 0;

	bezier_curve_segment_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// monitors: register writes, accepted points and accepted segments
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_point(in_word);
			if (out_valid && out_ready) sb.check_segment(out_word);
		end
	end

	// receiver: random stalls, a quiet stretch, and one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 14);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("bezier_curve_segment_generator verification failed");
			$finish;
		end
	end

	// valid rises at an edge and holds until the edge where ready is seen
	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
		in_word_t w;
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		w.point_x = x;
		w.point_y = y;
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) begin
			send_point(16'($urandom), 16'($urandom));
		end
	endtask

	// all owed words out, then room for a block still busy on a point
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int deg;
		int pts;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: cubic, 16 steps, extreme corners
		send_point(16'sh7fff, -16'sd32768);
		send_point(-16'sd32768, 16'sh7fff);
		send_point(16'sh7fff, 16'sh7fff);
		send_point(-16'sd32768, -16'sd32768);
		settle();

		// degree zero with zero steps: one degenerate segment per point
		write_reg(CFG_DEGREE, 0);
		write_reg(CFG_STEPS, 0);
		send_point(-16'sd1, 16'sd0);
		settle();

		// step count above the cap saturates
		write_reg(CFG_STEPS, 127);
		send_point(16'sd0, -16'sd1);
		settle();

		// full store: degree 15, alternating extremes
		write_reg(CFG_DEGREE, 15);
		for (int i = 0; i < STORE_N; i++) begin
			send_point(i[0] ? 16'sh7fff : -16'sd32768, i[1] ? -16'sd32768 : 16'sh7fff);
		end
		settle();

		// degree lowered while loading: curve drawn from the first two points
		write_reg(CFG_DEGREE, 5);
		write_reg(CFG_STEPS, 5);
		send_random(3);
		settle();
		write_reg(CFG_DEGREE, 1);
		send_random(1);
		settle();

		// random phases of well-formed curves, some partial or over-long loads
		for (int ph = 0; sent < ITEM_TARGET; ph++) begin
			calm = (ph >= 6 && ph < 10);
			deg  = ($urandom_range(19) == 0) ? $urandom_range(15, 8) : $urandom_range(4);
			write_reg(CFG_DEGREE, deg);
			case ($urandom_range(9))
				0:       write_reg(CFG_STEPS, 0);
				1:       write_reg(CFG_STEPS, (deg > 7) ? 8 : 64);
				2:       write_reg(CFG_STEPS, $urandom_range(127, 65));
				default: write_reg(CFG_STEPS, $urandom_range(12, 1));
			endcase
			if (ph == 3) hold_req = 1'b1;
			for (int c = 0; c < 3; c++) begin
				pts = deg + 1;
				if ($urandom_range(99) < 15) pts = $urandom_range(deg + 2, 1);
				send_random(pts);
			end
			settle();
		end
		calm = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.owed.size() != 0) begin
			sb.errors += sb.owed.size();
			$display("%0d segment words never arrived", sb.owed.size());
		end
		$display("%0d control points in, %0d curves drawn, %0d segments compared",
			sb.points, sb.curves, sb.segments);
		$display("mismatches: %0d, run length %0d cycles", sb.errors, cycles);
		if (sb.errors == 0) begin
			$display("bezier_curve_segment_generator verification clean");
		end else begin
			$display("bezier_curve_segment_generator verification failed");
		end
		$finish;
	end

endmodule
